// ===== rtl/core/rrts_pkg.sv =====
// Shared types, codes and constants of the round-robin thread scheduler.
package rrts_pkg;

  localparam int THREAD_SLOTS_DEF = 16;

  localparam int TID_W   = 4;
  localparam int PID_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int STATE_W = 3;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;

  // event codes
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_PREEMPT = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd4;

  // thread state codes
  localparam logic [STATE_W-1:0] TS_RUNNING = 3'd0;
  localparam logic [STATE_W-1:0] TS_READY   = 3'd1;
  localparam logic [STATE_W-1:0] TS_BLOCKED = 3'd2;
  localparam logic [STATE_W-1:0] TS_WAITING = 3'd3;
  localparam logic [STATE_W-1:0] TS_HANGING = 3'd4;
  localparam logic [STATE_W-1:0] TS_FREE    = 3'd5;

  // largest legal wait kind (hanging)
  localparam logic [KIND_W-1:0] KIND_MAX = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK            = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_BLOCKED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_KIND      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE_RUNNABLE = 3'd3;
  localparam logic [STAT_W-1:0] ST_SLOT_USED     = 3'd4;

  localparam logic [PRIO_W-1:0] MAIN_PRIO  = 8'd31;
  localparam logic [TID_W-1:0]  IDLE_RESET = 4'd1;
  localparam logic [PID_W-1:0]  PID_RESET  = 16'd1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  target_thread;
    logic [PRIO_W-1:0] priority_req;
    logic [KIND_W-1:0] block_kind;
  } sched_in_t;

  typedef struct packed {
    logic [TID_W-1:0]  active_thread;
    logic [TID_W-1:0]  previous_thread;
    logic              switched;
    logic [PID_W-1:0]  assigned_pid;
    logic [PRIO_W-1:0] slice_of_running;
    logic [STAT_W-1:0] status_code;
  } sched_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic disp;
    logic pop;
    logic wake;
    logic slice_rd;
    logic finish;
  } rrts_cmd_t;

  typedef struct packed {
    logic need_disp;
    logic ring_empty;
  } rrts_stat_t;

endpackage

// ===== rtl/core/rrts_ctrl.sv =====
// Sequencing state machine of the thread scheduler.
module rrts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  rrts_pkg::rrts_stat_t stat,
  output rrts_pkg::rrts_cmd_t  cmd,
  output logic              busy
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_WAKE  = 3'd4;
  localparam logic [2:0] S_SLICE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_disp ? S_DISP : S_SLICE;
      end
      S_DISP: begin
        cmd.disp   = 1'b1;
        state_next = stat.ring_empty ? S_WAKE : S_POP;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_SLICE;
      end
      S_WAKE: begin
        cmd.wake   = 1'b1;
        state_next = S_SLICE;
      end
      S_SLICE: begin
        cmd.slice_rd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/core/rrts_datapath.sv =====
// Thread table, ready ring, scheduler registers and result register.
module rrts_datapath #(
  parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rrts_pkg::rrts_cmd_t          cmd,
  output rrts_pkg::rrts_stat_t         stat,
  input  rrts_pkg::sched_in_t          event_word,
  input  logic                         cfg_valid,
  input  logic [rrts_pkg::TID_W-1:0]   cfg_data,
  output rrts_pkg::sched_out_t         result,
  output logic                         done
);
  import rrts_pkg::*;

  localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNT_W  = $clog2(THREAD_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(THREAD_SLOTS - 1);
  localparam logic [CNT_W-1:0]  RING_FULL = CNT_W'(THREAD_SLOTS);

  // scheduler registers
  sched_in_t         word, word_next;
  logic [SLOT_W-1:0] cur, cur_next;
  logic [SLOT_W-1:0] prev, prev_next;
  logic [SLOT_W-1:0] head, head_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PID_W-1:0]  pid, pid_next;
  logic [PID_W-1:0]  pid_out, pid_out_next;
  logic [STAT_W-1:0] status, status_next;
  logic              sw, sw_next;
  logic [TID_W-1:0]  idle;

  // thread table: state, priority and slice, one write and one read port
  logic [STATE_W-1:0] st_mem [THREAD_SLOTS];
  logic [PRIO_W-1:0]  pr_mem [THREAD_SLOTS];
  logic [PRIO_W-1:0]  sl_mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] st_vld, pr_vld, sl_vld;
  logic [STATE_W-1:0] st_q;
  logic [PRIO_W-1:0]  pr_q, sl_q;
  logic               st_vq, pr_vq, sl_vq, main_q;
  logic [STATE_W-1:0] e_state;
  logic [PRIO_W-1:0]  e_prio, e_slice;

  logic [SLOT_W-1:0]  t_raddr, t_waddr;
  logic               t_we_st, t_we_pr, t_we_sl;
  logic [STATE_W-1:0] t_wst;
  logic [PRIO_W-1:0]  t_wpr, t_wsl;

  // ready ring
  logic [SLOT_W-1:0] ring_mem [THREAD_SLOTS];
  logic [SLOT_W-1:0] ring_q;
  logic              r_we;
  logic [SLOT_W-1:0] r_waddr, r_wdata;

  logic [CNT_W:0]    tail_sum;
  logic [SLOT_W-1:0] tail, head_inc, head_dec;
  logic [SLOT_W-1:0] tgt_slot, idle_slot;
  logic              tgt_ok, idle_ok, e_wait, ring_room;

  // undefined entries read back as their reset contents
  assign e_state = st_vq ? st_q : (main_q ? TS_RUNNING : TS_FREE);
  assign e_prio  = pr_vq ? pr_q : (main_q ? MAIN_PRIO : '0);
  assign e_slice = sl_vq ? sl_q : (main_q ? MAIN_PRIO : '0);
  assign e_wait  = e_state inside {TS_BLOCKED, TS_WAITING, TS_HANGING};

  assign tgt_slot  = SLOT_W'(word.target_thread);
  assign idle_slot = SLOT_W'(idle);
  assign tgt_ok    = 32'(word.target_thread) < THREAD_SLOTS;
  assign idle_ok   = 32'(idle) < THREAD_SLOTS;

  assign tail_sum  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign tail      = (tail_sum >= (CNT_W+1)'(THREAD_SLOTS)) ?
                     SLOT_W'(tail_sum - (CNT_W+1)'(THREAD_SLOTS)) : SLOT_W'(tail_sum);
  assign head_inc  = (head == LAST_SLOT) ? '0 : head + 1'b1;
  assign head_dec  = (head == '0) ? LAST_SLOT : head - 1'b1;
  assign ring_room = (count != RING_FULL);

  assign stat.need_disp  = (word.op == OP_PREEMPT) || (word.op == OP_YIELD) ||
                           ((word.op == OP_BLOCK) && (word.block_kind <= KIND_MAX));
  assign stat.ring_empty = (count == '0);

  always_comb begin
    t_raddr = cur;
    if (cmd.load) begin
      if (event_word.op == OP_CREATE || event_word.op == OP_UNBLOCK) begin
        t_raddr = SLOT_W'(event_word.target_thread);
      end
    end else if (cmd.disp) begin
      t_raddr = idle_slot;
    end else if (cmd.slice_rd) begin
      t_raddr = cur;
    end
  end

  always_comb begin
    t_we_st = 1'b0;
    t_we_pr = 1'b0;
    t_we_sl = 1'b0;
    t_waddr = cur;
    t_wst   = TS_READY;
    t_wpr   = word.priority_req;
    t_wsl   = word.priority_req;
    r_we    = 1'b0;
    r_waddr = tail;
    r_wdata = cur;
    word_next    = word;
    cur_next     = cur;
    prev_next    = prev;
    head_next    = head;
    count_next   = count;
    pid_next     = pid;
    pid_out_next = pid_out;
    status_next  = status;
    sw_next      = sw;

    if (cmd.load) begin
      word_next    = event_word;
      prev_next    = cur;
      status_next  = ST_OK;
      sw_next      = 1'b0;
      pid_out_next = '0;
    end

    if (cmd.exec) begin
      case (word.op)
        OP_CREATE: begin
          if (tgt_ok && e_state == TS_FREE) begin
            pid_next     = pid + 1'b1;
            pid_out_next = pid + 1'b1;
            t_waddr = tgt_slot;
            t_we_st = 1'b1;
            t_we_pr = 1'b1;
            t_we_sl = 1'b1;
            if (ring_room) begin
              r_we       = 1'b1;
              r_wdata    = tgt_slot;
              count_next = count + 1'b1;
            end
          end else begin
            status_next = ST_SLOT_USED;
          end
        end
        OP_PREEMPT, OP_YIELD: begin
          if (e_state == TS_RUNNING) begin
            t_we_st = 1'b1;
            if (word.op == OP_PREEMPT) begin
              t_we_sl = 1'b1;
              t_wsl   = e_prio;
            end
            if (ring_room) begin
              r_we       = 1'b1;
              count_next = count + 1'b1;
            end
          end
        end
        OP_BLOCK: begin
          if (word.block_kind > KIND_MAX) begin
            status_next = ST_BAD_KIND;
          end else if (e_state == TS_RUNNING) begin
            t_we_st = 1'b1;
            t_wst   = TS_BLOCKED + STATE_W'(word.block_kind);
          end
        end
        OP_UNBLOCK: begin
          if (tgt_ok && e_wait) begin
            t_waddr = tgt_slot;
            t_we_st = 1'b1;
            if (ring_room) begin
              head_next  = head_dec;
              r_we       = 1'b1;
              r_waddr    = head_dec;
              r_wdata    = tgt_slot;
              count_next = count + 1'b1;
            end
          end else begin
            status_next = ST_NOT_BLOCKED;
          end
        end
        default: ;
      endcase
    end

    // pop the head of the ring into the running slot
    if (cmd.pop) begin
      head_next  = head_inc;
      count_next = count - 1'b1;
      cur_next   = ring_q;
      sw_next    = 1'b1;
      t_waddr    = ring_q;
      t_we_st    = 1'b1;
      t_wst      = TS_RUNNING;
    end

    // empty ring: wake the idle slot straight into running
    if (cmd.wake) begin
      if (idle_ok && e_wait) begin
        cur_next = idle_slot;
        sw_next  = 1'b1;
        t_waddr  = idle_slot;
        t_we_st  = 1'b1;
        t_wst    = TS_RUNNING;
      end else begin
        status_next = ST_NONE_RUNNABLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (t_we_st) st_mem[t_waddr] <= t_wst;
    if (t_we_pr) pr_mem[t_waddr] <= t_wpr;
    if (t_we_sl) sl_mem[t_waddr] <= t_wsl;
    if (r_we) ring_mem[r_waddr] <= r_wdata;
    st_q   <= st_mem[t_raddr];
    pr_q   <= pr_mem[t_raddr];
    sl_q   <= sl_mem[t_raddr];
    st_vq  <= st_vld[t_raddr];
    pr_vq  <= pr_vld[t_raddr];
    sl_vq  <= sl_vld[t_raddr];
    main_q <= (t_raddr == '0);
    ring_q <= ring_mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
      pr_vld <= '0;
      sl_vld <= '0;
      cur    <= '0;
      head   <= '0;
      count  <= '0;
      pid    <= PID_RESET;
      idle   <= IDLE_RESET;
      done   <= 1'b0;
    end else begin
      if (t_we_st) st_vld[t_waddr] <= 1'b1;
      if (t_we_pr) pr_vld[t_waddr] <= 1'b1;
      if (t_we_sl) sl_vld[t_waddr] <= 1'b1;
      cur   <= cur_next;
      head  <= head_next;
      count <= count_next;
      pid   <= pid_next;
      if (cfg_valid) idle <= cfg_data;
      done  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    word    <= word_next;
    prev    <= prev_next;
    pid_out <= pid_out_next;
    status  <= status_next;
    sw      <= sw_next;
    if (cmd.finish) begin
      result.active_thread    <= TID_W'(cur);
      result.previous_thread  <= TID_W'(prev);
      result.switched         <= sw;
      result.assigned_pid     <= pid_out;
      result.slice_of_running <= e_slice;
      result.status_code      <= status;
    end
  end

endmodule

// ===== rtl/core/round_robin_thread_scheduler_core.sv =====
// Top level of the round-robin thread scheduler: controller, datapath and checks.
// Sequence: load, execute, slice read, result; preempt, yield and legal-kind block add
//   dispatch and pop or wake after execute; done strobes for one cycle with the result.
// Events: one at a time through the controller's step sequence; busy holds off start
//   until the result word is out, and the receiver cannot stall.
// Reset: synchronous; slot 0 runs, all others are free and the ring is empty at once.
module round_robin_thread_scheduler_core #(
  parameter int THREAD_SLOTS = rrts_pkg::THREAD_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  rrts_pkg::sched_in_t        event_word,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rrts_pkg::TID_W-1:0] cfg_data,
  output rrts_pkg::sched_out_t       result,
  output logic                       done
);
  import rrts_pkg::*;

  rrts_cmd_t  cmd;
  rrts_stat_t stat;

  // The idle-slot register takes a write on any cycle.
  assign cfg_ready = 1'b1;

  // Step through load, execute, optional dispatch, slice read and result.
  rrts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the thread table, the ready ring and the scheduler registers.
  rrts_datapath #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .event_word (event_word),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .result     (result),
    .done       (done)
  );

`ifndef SYNTH
  // A result word never overlaps a word in flight.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A dispatch always reports success.
  a_switch_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.switched) |-> (result.status_code == ST_OK))
    else $error("switch reported with error status");

  // The running slot only moves on a dispatch.
  a_no_switch_keep: assert property (@(posedge clk) disable iff (rst)
    (done && !result.switched) |-> (result.active_thread == result.previous_thread))
    else $error("running thread changed without a switch");

  // A PID is handed out only by an event that succeeded.
  a_pid_on_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status_code != ST_OK)) |-> (result.assigned_pid == '0))
    else $error("PID given on failed event");
`endif

endmodule
